@@ rtl/flow_table_quadratic_probe_unit_defines.svh @@
// Assertion helpers for the flow table.
`ifndef FLOW_TABLE_QUADRATIC_PROBE_UNIT_DEFINES_SVH
`define FLOW_TABLE_QUADRATIC_PROBE_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define FTQ_ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define FTQ_ASSERT_NORST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define FTQ_ASSERT_CLK(label, clk, rst_n, prop, msg)
`define FTQ_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

@@ rtl/ftqp_pkg.sv @@
package ftqp_pkg;
    localparam int KEY_W = 112;
    // The probe index is reduced modulo the table size by masking, so the
    // size is fixed here as a power of two.
    localparam int TABLE_ENTRIES = 4096;
    localparam logic [1:0] ST_EMPTY   = 2'd0;
    localparam logic [1:0] ST_SENT    = 2'd1;
    localparam logic [1:0] ST_UNSENT  = 2'd2;
    localparam logic [1:0] ST_DELETED = 2'd3;
    localparam logic [1:0] FN_LOOKUP  = 2'd0;
    localparam logic [1:0] FN_REBASE  = 2'd1;
    localparam logic [1:0] FN_MARK    = 2'd2;
    localparam logic [1:0] FN_UNUSED  = 2'd3;
    localparam logic [2:0] RS_HIT     = 3'd0;
    localparam logic [2:0] RS_INSERT  = 3'd1;
    localparam logic [2:0] RS_DROP_T  = 3'd2;
    localparam logic [2:0] RS_DROP_N  = 3'd3;
    localparam logic [2:0] RS_DONE    = 3'd4;
    localparam logic [2:0] CFG_LIN    = 3'd0;
    localparam logic [2:0] CFG_SQR    = 3'd1;
    localparam logic [2:0] CFG_EXP    = 3'd2;
    localparam logic [2:0] CFG_MAX    = 3'd3;
    localparam logic [2:0] CFG_MIN    = 3'd4;
    localparam logic [31:0] FNV_BASIS = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME = 32'd16777619;
    localparam logic [5:0] PKT_MAX    = 6'd63;
endpackage

@@ rtl/flow_table_quadratic_probe_unit.sv @@
// Flow table with open addressing and quadratic probing.
// Input stream s_axis: one item per transfer (operation, flow key, time).
// Output stream m_axis: exactly one result per accepted item.
// The configuration port writes one register per cycle; the user must write
// it only while the block is idle, as the block itself does not enforce this.
// A lookup hashes the 14 key bytes one byte per cycle, then probes up to
// NUM_PROBES slots, each a registered read of the status and entry memories
// (S_RD) followed by an evaluate/write step (S_EVAL). The quadratic index
// is built incrementally with adds only. A rebase or mark operation sweeps
// the whole table, reading and then evaluating or rewriting each entry in turn.
// The block accepts the next item in the cycle after the result transfer.
// After reset a clearing pass over all TABLE_ENTRIES slots empties the status
// memory; no item is accepted until it ends. Counters and base time reset
// to zero and registers to their documented values.
// While the receiver stalls, the result stays in the output register
// and no new item is accepted.
`include "flow_table_quadratic_probe_unit_defines.svh"
module flow_table_quadratic_probe_unit
    import ftqp_pkg::*;
#(
    parameter int NUM_PROBES    = 8,
    parameter int FIRST_FLOW_ID = 1
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata: source_ip, dest_ip, source_port, dest_port, protocol, tcp_flags,
    // now_seconds (lowest first)
    input  logic [143:0] s_axis_tdata,
    // tuser: func
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata: flow_id, packet_count, live_flows, expired_total, dropped_total
    output logic [95:0]  m_axis_tdata,
    // tuser: status
    output logic [2:0]   m_axis_tuser,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_wdata
);
    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam int PW = $clog2(NUM_PROBES + 1);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_HASH, S_CHECK, S_RD, S_EVAL, S_INSERT,
        S_SW_RD, S_SW_EVAL, S_OUT
    } t_state;

    t_state r_state;

    logic [1:0]       r_status_mem [TABLE_ENTRIES];
    logic [KEY_W+37:0] r_entry_mem [TABLE_ENTRIES];

    logic [31:0] r_lin, r_sqr, r_exp;
    logic [30:0] r_max;
    logic [31:0] r_min;
    logic [31:0] r_base;
    logic [12:0] r_occ;
    logic [31:0] r_expired, r_dropped;

    logic [1:0]        r_func;
    logic [KEY_W-1:0]  r_key;
    logic [31:0]       r_now;
    logic [31:0]       r_hash;
    logic [3:0]        r_byte;
    logic [31:0]       r_idx, r_delta;
    logic [PW-1:0]     r_probe;
    logic              r_have_free;
    logic [AW-1:0]     r_free;
    logic [AW:0]       r_sweep;

    logic [1:0]        r_rd_status;
    logic [KEY_W+37:0] r_rd_entry;

    logic [2:0]  r_o_status;
    logic [12:0] r_o_flow;
    logic [5:0]  r_o_pkt;

    logic [AW-1:0] w_addr;
    logic [7:0]    w_byte;
    logic [31:0]   w_hash_x;
    logic [63:0]   w_hash_m;
    logic signed [33:0] w_diff;
    logic [31:0]   w_off_now;
    logic [KEY_W-1:0] w_ekey;
    logic [5:0]    w_epkt;
    logic [31:0]   w_eoff;
    logic signed [34:0] w_expire_sum;
    logic          w_expire, w_live, w_hit;
    logic signed [33:0] w_sw_diff;
    logic signed [34:0] w_sw_off;

    assign w_addr   = r_idx[AW-1:0];
    assign w_byte   = r_key[r_byte*8 +: 8];
    assign w_hash_x = r_hash ^ {24'd0, w_byte};
    assign w_hash_m = w_hash_x * FNV_PRIME;
    assign w_diff   = $signed({2'b00, r_now}) - $signed({2'b00, r_base});
    assign w_off_now = r_now - r_base;
    assign w_ekey   = r_rd_entry[KEY_W+37:38];
    assign w_epkt   = r_rd_entry[37:32];
    assign w_eoff   = r_rd_entry[31:0];
    assign w_expire_sum = $signed({3'b000, r_base}) + $signed({{3{w_eoff[31]}}, w_eoff})
                        + $signed({3'b000, r_exp});
    assign w_expire = (r_rd_status == ST_SENT) &&
                      (w_expire_sum < $signed({3'b000, r_now}));
    assign w_live   = !w_expire && (r_rd_status == ST_SENT || r_rd_status == ST_UNSENT);
    assign w_hit    = w_live && (w_ekey == r_key);
    assign w_sw_diff = w_diff;
    assign w_sw_off  = $signed({{3{w_eoff[31]}}, w_eoff}) - $signed({w_sw_diff[33], w_sw_diff});

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tuser  = r_o_status;
    assign m_axis_tdata  = {r_dropped, r_expired, r_occ, r_o_pkt, r_o_flow};

    // Memory ports: one read and one write per cycle.
    always_ff @(posedge i_clk) begin
        if (r_state == S_RD || r_state == S_SW_RD) begin
            r_rd_status <= r_status_mem[w_addr];
            r_rd_entry  <= r_entry_mem[w_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_sweep <= '0;
            r_lin <= 32'd1; r_sqr <= 32'd1; r_exp <= 32'd300;
            r_max <= 31'd65535; r_min <= 32'd0;
            r_base <= '0; r_occ <= '0; r_expired <= '0; r_dropped <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_LIN: r_lin <= i_cfg_wdata;
                    CFG_SQR: r_sqr <= i_cfg_wdata;
                    CFG_EXP: r_exp <= i_cfg_wdata;
                    CFG_MAX: r_max <= i_cfg_wdata[30:0];
                    CFG_MIN: r_min <= i_cfg_wdata;
                    default: ;
                endcase
            end
            case (r_state)
                S_CLEAR: begin
                    r_status_mem[r_sweep[AW-1:0]] <= ST_EMPTY;
                    r_sweep <= r_sweep + 1'b1;
                    if (r_sweep == (AW+1)'(TABLE_ENTRIES - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_func <= s_axis_tuser;
                        r_key  <= s_axis_tdata[KEY_W-1:0];
                        r_now  <= s_axis_tdata[143:112];
                        r_hash <= FNV_BASIS;
                        r_byte <= '0;
                        r_sweep <= '0;
                        r_o_status <= RS_DONE; r_o_flow <= '0; r_o_pkt <= '0;
                        case (s_axis_tuser)
                            FN_LOOKUP: r_state <= S_HASH;
                            FN_REBASE, FN_MARK: begin
                                r_idx <= '0;
                                r_state <= S_SW_RD;
                            end
                            default: r_state <= S_OUT;
                        endcase
                    end
                end
                S_HASH: begin
                    r_hash <= w_hash_m[31:0];
                    r_byte <= r_byte + 1'b1;
                    if (r_byte == 4'd13) r_state <= S_CHECK;
                end
                S_CHECK: begin
                    r_idx <= r_hash;
                    r_delta <= r_lin + r_sqr;
                    r_probe <= '0;
                    r_have_free <= 1'b0;
                    if (r_occ != 0 && (w_diff > $signed({3'b000, r_max}) ||
                        w_diff < $signed({{2{r_min[31]}}, r_min}))) begin
                        r_dropped <= r_dropped + 1'b1;
                        r_o_status <= RS_DROP_T;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_RD;
                    end
                end
                S_RD: r_state <= S_EVAL;
                S_EVAL: begin
                    if (w_expire) begin
                        r_status_mem[w_addr] <= ST_DELETED;
                        r_occ <= r_occ - 1'b1;
                        r_expired <= r_expired + 1'b1;
                    end
                    if (w_hit) begin
                        r_entry_mem[w_addr] <= {w_ekey,
                            (r_rd_status == ST_UNSENT && w_epkt < PKT_MAX) ?
                            w_epkt + 6'd1 : w_epkt, w_off_now};
                        r_o_status <= RS_HIT;
                        r_o_flow <= 13'(w_addr) + 13'(FIRST_FLOW_ID);
                        r_o_pkt <= (r_rd_status == ST_UNSENT && w_epkt < PKT_MAX) ?
                            w_epkt + 6'd1 : w_epkt;
                        r_state <= S_OUT;
                    end else begin
                        if (!w_live && !r_have_free) begin
                            r_have_free <= 1'b1;
                            r_free <= w_addr;
                        end
                        // The square term grows by S*(2p+1) each probe.
                        r_idx <= r_idx + r_delta;
                        r_delta <= r_delta + (r_sqr << 1);
                        r_probe <= r_probe + 1'b1;
                        if ((r_rd_status == ST_EMPTY) ||
                            r_probe == PW'(NUM_PROBES - 1)) begin
                            r_state <= S_INSERT;
                        end else begin
                            r_state <= S_RD;
                        end
                    end
                end
                S_INSERT: begin
                    if (!r_have_free) begin
                        r_dropped <= r_dropped + 1'b1;
                        r_o_status <= RS_DROP_N;
                    end else begin
                        r_status_mem[r_free] <= ST_UNSENT;
                        r_entry_mem[r_free] <= {r_key, 6'd1,
                            (r_occ == 0) ? 32'd0 : w_off_now};
                        if (r_occ == 0) r_base <= r_now;
                        r_occ <= r_occ + 1'b1;
                        r_o_status <= RS_INSERT;
                        r_o_flow <= 13'(r_free) + 13'(FIRST_FLOW_ID);
                        r_o_pkt <= 6'd1;
                    end
                    r_state <= S_OUT;
                end
                S_SW_RD: r_state <= S_SW_EVAL;
                S_SW_EVAL: begin
                    if (r_rd_status == ST_SENT || r_rd_status == ST_UNSENT) begin
                        if (r_func == FN_MARK) begin
                            if (r_rd_status == ST_UNSENT) r_status_mem[w_addr] <= ST_SENT;
                        end else if (w_sw_off < $signed({{3{r_min[31]}}, r_min})) begin
                            r_status_mem[w_addr] <= ST_DELETED;
                            r_occ <= r_occ - 1'b1;
                        end else begin
                            r_entry_mem[w_addr] <= {w_ekey, w_epkt,
                                w_eoff - w_off_now};
                        end
                    end
                    r_idx <= r_idx + 32'd1;
                    if (w_addr == AW'(TABLE_ENTRIES - 1)) begin
                        if (r_func == FN_REBASE) r_base <= r_now;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_SW_RD;
                    end
                end
                S_OUT: if (m_axis_tready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `FTQ_ASSERT_CLK(a_no_accept_busy, i_clk, i_rst_n,
        (s_axis_tready |-> !m_axis_tvalid), "input accepted while result pending")
    `FTQ_ASSERT_CLK(a_occ_bound, i_clk, i_rst_n,
        (r_occ <= 13'(TABLE_ENTRIES)), "occupancy beyond table size")
    `FTQ_ASSERT_CLK(a_out_status, i_clk, i_rst_n,
        (m_axis_tvalid |-> (m_axis_tuser <= RS_DONE)), "bad result status")
    `FTQ_ASSERT_NORST(a_reset_clear, i_clk,
        (!i_rst_n |=> !s_axis_tready), "accepting right after reset")
endmodule

@@ sim/flow_table_quadratic_probe_unit_checker.sv @@
module flow_table_quadratic_probe_unit_checker
    import ftqp_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [143:0] s_axis_tdata,
    input  logic [1:0]   s_axis_tuser,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [95:0]  m_axis_tdata,
    input  logic [2:0]   m_axis_tuser,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_wdata,
    output int           o_pending,
    output int           o_checked,
    output int           o_errors
);
    localparam int NUM_PROBES    = 8;
    localparam int FIRST_FLOW_ID = 1;

    typedef struct packed {
        logic [2:0]  status;
        logic [12:0] flow_id;
        logic [5:0]  packets;
        logic [12:0] live;
        logic [31:0] expired;
        logic [31:0] dropped;
    } t_flow_result;

    logic [1:0]          slot_st  [TABLE_ENTRIES];
    logic [111:0]        slot_key [TABLE_ENTRIES];
    logic [5:0]          slot_pkts[TABLE_ENTRIES];
    logic signed [31:0]  slot_off [TABLE_ENTRIES];
    logic [31:0]         base_time, expired_cnt, dropped_cnt;
    logic [12:0]         live_cnt;
    logic [31:0]         lin_step, sq_step, expire_s;
    logic [30:0]         max_off;
    logic signed [31:0]  min_off;

    t_flow_result expected_results[$];
    int errors, checked;

    // FNV-1a over the 14 key bytes; the packed key already holds them in hash order.
    function automatic logic [31:0] key_hash(input logic [111:0] key);
        logic [31:0] h;
        h = FNV_BASIS;
        for (int i = 0; i < 14; i++) begin
            h = (h ^ {24'b0, key[8*i +: 8]}) * FNV_PRIME;
        end
        return h;
    endfunction

    function automatic logic is_live(input logic [1:0] st);
        return st == ST_SENT || st == ST_UNSENT;
    endfunction

    function automatic t_flow_result apply_item(input logic [1:0] fn, input logic [111:0] key,
                                                input logic [31:0] now);
        t_flow_result res;
        longint diff;
        logic [31:0] h, p;
        logic [11:0] idx, free_idx;
        logic have_free, finished;
        res = '0;
        res.status = RS_DONE;
        if (fn == FN_LOOKUP) begin
            diff = longint'(now) - longint'(base_time);
            if (live_cnt > 0 && (diff > longint'(max_off) || diff < longint'(min_off))) begin
                dropped_cnt++;
                res.status = RS_DROP_T;
            end else begin
                h = key_hash(key);
                have_free = 0;
                finished = 0;
                free_idx = '0;
                for (int i = 0; i < NUM_PROBES; i++) begin
                    if (!finished) begin
                        p = i;
                        idx = 12'(h + lin_step * p + sq_step * p * p);
                        if (slot_st[idx] == ST_SENT && longint'(base_time)
                            + longint'(slot_off[idx]) + longint'(expire_s) < longint'(now)) begin
                            slot_st[idx] = ST_DELETED;
                            live_cnt--;
                            expired_cnt++;
                        end
                        if (is_live(slot_st[idx]) && slot_key[idx] == key) begin
                            slot_off[idx] = now - base_time;
                            if (slot_st[idx] == ST_UNSENT && slot_pkts[idx] < PKT_MAX)
                                slot_pkts[idx]++;
                            res.status = RS_HIT;
                            res.flow_id = 13'(idx) + 13'(FIRST_FLOW_ID);
                            res.packets = slot_pkts[idx];
                            finished = 1;
                        end else if (!is_live(slot_st[idx])) begin
                            if (!have_free) begin
                                have_free = 1;
                                free_idx = idx;
                            end
                            if (slot_st[idx] == ST_EMPTY) finished = 1;
                        end
                    end
                end
                if (res.status != RS_HIT) begin
                    if (!have_free) begin
                        dropped_cnt++;
                        res.status = RS_DROP_N;
                    end else begin
                        if (live_cnt == 0) base_time = now;
                        slot_st[free_idx] = ST_UNSENT;
                        slot_key[free_idx] = key;
                        slot_pkts[free_idx] = 6'd1;
                        slot_off[free_idx] = now - base_time;
                        live_cnt++;
                        res.status = RS_INSERT;
                        res.flow_id = 13'(free_idx) + 13'(FIRST_FLOW_ID);
                        res.packets = 6'd1;
                    end
                end
            end
        end else if (fn == FN_REBASE) begin
            diff = longint'(now) - longint'(base_time);
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                if (is_live(slot_st[i])) begin
                    if (longint'(slot_off[i]) - diff < longint'(min_off)) begin
                        slot_st[i] = ST_DELETED;
                        live_cnt--;
                    end else begin
                        slot_off[i] = slot_off[i] - 32'(diff);
                    end
                end
            end
            base_time = now;
        end else if (fn == FN_MARK) begin
            for (int i = 0; i < TABLE_ENTRIES; i++)
                if (slot_st[i] == ST_UNSENT) slot_st[i] = ST_SENT;
        end
        res.live = live_cnt;
        res.expired = expired_cnt;
        res.dropped = dropped_cnt;
        return res;
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch on result %0d: %s got %0h expected %0h", checked, what, got, want);
        errors++;
    endtask

    always @(posedge i_clk) begin
        t_flow_result want, got;
        if (!i_rst_n) begin
            for (int i = 0; i < TABLE_ENTRIES; i++) slot_st[i] = ST_EMPTY;
            base_time = 0;
            live_cnt = 0;
            expired_cnt = 0;
            dropped_cnt = 0;
            lin_step = 1;
            sq_step = 1;
            expire_s = 300;
            max_off = 65535;
            min_off = 0;
            expected_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_LIN: lin_step = i_cfg_wdata;
                    CFG_SQR: sq_step = i_cfg_wdata;
                    CFG_EXP: expire_s = i_cfg_wdata;
                    CFG_MAX: max_off = i_cfg_wdata[30:0];
                    CFG_MIN: min_off = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got = {m_axis_tuser, m_axis_tdata[12:0], m_axis_tdata[18:13],
                       m_axis_tdata[31:19], m_axis_tdata[63:32], m_axis_tdata[95:64]};
                if (expected_results.size() == 0) begin
                    report("unexpected result status", 32'(m_axis_tuser), 32'd0);
                end else begin
                    want = expected_results.pop_front();
                    if (got.status != want.status)
                        report("status", 32'(got.status), 32'(want.status));
                    if (got.flow_id != want.flow_id)
                        report("flow_id", 32'(got.flow_id), 32'(want.flow_id));
                    if (got.packets != want.packets)
                        report("packet_count", 32'(got.packets), 32'(want.packets));
                    if (got.live != want.live)
                        report("live_flows", 32'(got.live), 32'(want.live));
                    if (got.expired != want.expired)
                        report("expired_total", got.expired, want.expired);
                    if (got.dropped != want.dropped)
                        report("dropped_total", got.dropped, want.dropped);
                end
                checked++;
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_results.push_back(apply_item(s_axis_tuser, s_axis_tdata[111:0],
                                                      s_axis_tdata[143:112]));
        end
        o_pending <= expected_results.size();
        o_checked <= checked;
        o_errors <= errors;
    end
endmodule

@@ sim/flow_table_quadratic_probe_unit_tb.sv @@
module flow_table_quadratic_probe_unit_tb;
    import ftqp_pkg::*;

    localparam longint CYCLE_LIMIT = 3000000;
    localparam int     PHASE_ITEMS = 80;

    logic         i_clk, i_rst_n;
    logic         s_axis_tvalid, s_axis_tready;
    logic [143:0] s_axis_tdata;
    logic [1:0]   s_axis_tuser;
    logic         m_axis_tvalid, m_axis_tready;
    logic [95:0]  m_axis_tdata;
    logic [2:0]   m_axis_tuser;
    logic         i_cfg_we;
    logic [2:0]   i_cfg_index;
    logic [31:0]  i_cfg_wdata;
    int           pending, checked, errors;

    logic         quiet;
    longint       cycles;
    int           items_sent;
    logic [31:0]  tbase;
    logic [111:0] key_pool[16];

    flow_table_quadratic_probe_unit uut (.*);

    flow_table_quadratic_probe_unit_checker chk (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
        .i_cfg_we, .i_cfg_index, .i_cfg_wdata,
        .o_pending(pending), .o_checked(checked), .o_errors(errors)
    );

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAIL flow_table_quadratic_probe_unit");
            $finish;
        end
    end

    function automatic int pick_gap();
        return quiet ? 0 : $urandom_range(0, 12);
    endfunction

    function automatic logic [111:0] random_key();
        return 112'({$urandom(), $urandom(), $urandom(), $urandom()});
    endfunction

    task automatic send_flow_item(input logic [1:0] fn, input logic [111:0] key,
                                  input logic [31:0] now);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tuser <= fn;
        s_axis_tdata <= {now, key};
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
        items_sent++;
    endtask

    // Lets every result drain, plus a margin for the block to settle.
    task automatic wait_drained();
        s_axis_tvalid <= 0;
        do @(posedge i_clk); while (pending != 0);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        i_cfg_we <= 1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
    endtask

    task automatic set_probe_config(input logic [31:0] lin, input logic [31:0] sq,
                                    input logic [31:0] expire, input logic [31:0] max_o,
                                    input logic [31:0] min_o);
        write_reg(CFG_LIN, lin);
        write_reg(CFG_SQR, sq);
        write_reg(CFG_EXP, expire);
        write_reg(CFG_MAX, max_o & 32'h7FFF_FFFF);
        write_reg(CFG_MIN, min_o);
        i_cfg_we <= 0;
    endtask

    // Returns a key whose home slot equals that of the given key.
    function automatic logic [111:0] colliding_key(input logic [111:0] key);
        logic [111:0] k;
        logic [11:0] home;
        home = 12'(chk.key_hash(key));
        do k = random_key(); while (12'(chk.key_hash(k)) != home || k == key);
        return k;
    endfunction

    // Receiver: stalls for a random number of cycles before each result.
    initial begin
        int gap;
        m_axis_tready = 0;
        @(posedge i_rst_n);
        forever begin
            gap = pick_gap();
            if (gap > 0) begin
                m_axis_tready <= 0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1;
            do @(posedge i_clk); while (!(m_axis_tvalid && m_axis_tready));
        end
    end

    initial begin
        logic [111:0] key_a, key_c, key_d;
        logic [31:0]  t0, now;
        logic [1:0]   fn;
        int           roll;
        items_sent = 0;
        quiet = 0;
        i_rst_n = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        i_cfg_we = 0;
        i_cfg_index = '0;
        i_cfg_wdata = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;

        // Directed part under the reset configuration.
        t0 = 32'h8000_0000;
        key_a = random_key();
        send_flow_item(FN_UNUSED, '1, '1);
        send_flow_item(FN_MARK, '0, '0);
        send_flow_item(FN_REBASE, '0, '0);
        send_flow_item(FN_LOOKUP, key_a, t0);
        send_flow_item(FN_LOOKUP, key_a, t0 + 5);
        send_flow_item(FN_LOOKUP, '1, t0);
        send_flow_item(FN_LOOKUP, '0, t0 + 1);
        send_flow_item(FN_LOOKUP, key_a, t0 + 65536);
        send_flow_item(FN_LOOKUP, key_a, t0 - 1);
        send_flow_item(FN_LOOKUP, '0, '1);
        send_flow_item(FN_MARK, '0, '0);
        send_flow_item(FN_LOOKUP, '1, t0 + 10);
        send_flow_item(FN_LOOKUP, key_a, t0 + 400);
        send_flow_item(FN_REBASE, '0, t0 + 50);
        send_flow_item(FN_LOOKUP, key_a, t0 + 60);
        wait_drained();

        // Every probe lands on one slot, so a colliding key finds no room.
        set_probe_config(32'd0, 32'd0, 32'd300, 32'd65535, 32'd0);
        key_c = random_key();
        key_d = colliding_key(key_c);
        send_flow_item(FN_LOOKUP, key_c, t0 + 70);
        send_flow_item(FN_LOOKUP, key_d, t0 + 71);
        send_flow_item(FN_LOOKUP, key_c, t0 + 72);
        wait_drained();

        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: set_probe_config($urandom(), $urandom(), $urandom_range(0, 60),
                                    $urandom_range(100, 2000), -$urandom_range(0, 500));
                1: set_probe_config('1, '1, 32'd0, 32'h7FFF_FFFF, 32'h8000_0000);
                2: set_probe_config(32'h1000, 32'h2000, '1, 32'd0, 32'd0);
                3: set_probe_config(32'd1, 32'd1, 32'd300, 32'd65535, 32'd0);
                default: set_probe_config($urandom(), $urandom(), $urandom_range(0, 200),
                                          $urandom(), -$urandom_range(0, 100));
            endcase
            for (int i = 0; i < 16; i++) key_pool[i] = random_key();
            tbase = $urandom();
            send_flow_item(FN_REBASE, '0, tbase);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                quiet = (n >= PHASE_ITEMS / 2) && (phase % 2 == 0);
                roll = $urandom_range(0, 99);
                now = tbase + $urandom_range(0, 80);
                if (roll < 3) begin
                    tbase = tbase + $urandom_range(0, 100);
                    send_flow_item(FN_REBASE, random_key(), tbase);
                end else if (roll < 7) begin
                    send_flow_item(FN_MARK, random_key(), $urandom());
                end else if (roll < 9) begin
                    send_flow_item(FN_UNUSED, random_key(), $urandom());
                end else begin
                    fn = FN_LOOKUP;
                    if (roll < 17) now = $urandom();
                    else if (roll < 22) now = tbase - $urandom_range(0, 600);
                    send_flow_item(fn, roll < 80 ? key_pool[$urandom_range(0, 15)]
                                                 : random_key(), now);
                end
            end
            quiet = 0;
            wait_drained();
        end

        $display("%0d items sent, %0d results checked across several probe settings",
                 items_sent, checked);
        $display("covered hits, inserts, expiry, both drop kinds, rebase and mark sweeps");
        if (errors == 0) begin
            $display("PASS flow_table_quadratic_probe_unit");
        end else begin
            $display("FAIL flow_table_quadratic_probe_unit");
        end
        $finish;
    end
endmodule
